// ----- rtl/core/mmc3_pkg.sv -----
// Shared constants for the MMC3-style bank mapper core.
// Holds bus operation codes, address decode values and reset defaults.
// No dependencies; mmc3_ifs and the top-level core use it.
`timescale 1ns / 1ps

package mmc3_pkg;

  // Field widths of the bus beats.
  localparam int OpW       = 3;
  localparam int AddrW     = 16;
  localparam int DataW     = 8;
  localparam int MapAddrW  = 19;
  localparam int BankCntW  = 6;
  localparam int PrgBankW  = 6;
  localparam int ChrBankW  = 8;
  localparam int BankRegW  = 8;

  // Operation codes.
  localparam logic [OpW-1:0] OpCpuRead  = 3'd0;
  localparam logic [OpW-1:0] OpCpuWrite = 3'd1;
  localparam logic [OpW-1:0] OpPpuRead  = 3'd2;
  localparam logic [OpW-1:0] OpScanline = 3'd3;
  localparam logic [OpW-1:0] OpIrqClear = 3'd4;

  // CPU register windows, selected by address bits 14:13 above 0x8000.
  localparam logic [1:0] WinBank   = 2'd0;
  localparam logic [1:0] WinMirror = 2'd1;
  localparam logic [1:0] WinIrqCnt = 2'd2;
  localparam logic [1:0] WinIrqEn  = 2'd3;

  // Address bits 15:13 of the PRG RAM window at 0x6000.
  localparam logic [2:0] RamWindow = 3'b011;

  // Reset values and the PRG RAM depth.
  localparam int                   PrgRamDepth   = 8192;
  localparam logic [BankCntW-1:0]  BankCntReset  = 6'd16;
  localparam logic [PrgBankW-1:0]  PrgLastReset  = PrgBankW'((2 * 16 - 1) % 64);
  localparam logic [PrgBankW-1:0]  PrgSecLastRst = PrgBankW'((2 * 16 - 2) % 64);

endpackage

// ----- rtl/core/mmc3_ifs.sv -----
// Valid/ready channel interfaces of the mapper core: bus events in,
// results out and the PRG bank count write port. Depends on mmc3_pkg.
`timescale 1ns / 1ps

interface mmc3_in_if;
  logic                          valid;
  logic                          ready;
  logic [mmc3_pkg::OpW-1:0]      operation;
  logic [mmc3_pkg::AddrW-1:0]    address;
  logic [mmc3_pkg::DataW-1:0]    write_data;

  modport source (output valid, output operation, output address, output write_data,
                  input ready);
  modport sink (input valid, input operation, input address, input write_data,
                output ready);
endinterface

interface mmc3_out_if;
  logic                          valid;
  logic                          ready;
  logic                          handled;
  logic                          ram_hit;
  logic [mmc3_pkg::MapAddrW-1:0] mapped_address;
  logic [mmc3_pkg::DataW-1:0]    read_data;
  logic                          irq_line;
  logic                          mirror_horizontal;

  modport source (output valid, output handled, output ram_hit, output mapped_address,
                  output read_data, output irq_line, output mirror_horizontal,
                  input ready);
  modport sink (input valid, input handled, input ram_hit, input mapped_address,
                input read_data, input irq_line, input mirror_horizontal,
                output ready);
endinterface

interface mmc3_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mmc3_pkg::BankCntW-1:0] prg_bank_count;

  modport source (output valid, output prg_bank_count, input ready);
  modport sink (input valid, input prg_bank_count, output ready);
endinterface

// ----- rtl/core/mmc3_ram.sv -----
// Generic single-port RAM with a registered read port.
// Used for the cartridge PRG RAM; no dependencies.
`timescale 1ns / 1ps

module mmc3_ram #(
  parameter int Width = 8,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/mmc3_bank_mapper_irq_core.sv -----
// Top level of the MMC3-style bank mapper with scanline IRQ counter.
// Depends on mmc3_pkg, the channel interfaces in mmc3_ifs and mmc3_ram.
`timescale 1ns / 1ps

// How to use this block:
// Bus events (CPU read or write, PPU read, scanline tick, IRQ clear) arrive
// as beats on in_i; every beat yields exactly one result beat on out_o, in
// order. cfg_i writes the number of 16KB PRG banks; it is always ready and
// is to be written only while no beat is in flight.
// Mapper state is updated at the edge that accepts a beat. A PRG RAM read goes
// through the registered RAM port, so each result passes the read stage and
// then the output register before it is offered. One beat is accepted per
// cycle while in_i is ready. Two registers (the RAM read stage and the output
// register) hold results, so the input keeps accepting while a result waits;
// only when both are full and out_o is stalled does in_i drop ready.
// Reset clears the bank registers, CHR table, IRQ state and mode bits, sets
// horizontal mirroring and a bank count of 16 with the last two 8KB PRG
// banks mapped high. PRG RAM contents are not cleared and must be written
// before they are read.
module mmc3_bank_mapper_irq_core #(
  parameter int PRG_RAM_DEPTH = mmc3_pkg::PrgRamDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  mmc3_in_if.sink    in_i,
  mmc3_out_if.source out_o,
  mmc3_cfg_if.sink   cfg_i
);

  localparam int RamAw = $clog2(PRG_RAM_DEPTH);

  typedef struct packed {
    logic                          handled;
    logic                          ram_hit;
    logic [mmc3_pkg::MapAddrW-1:0] mapped_address;
    logic                          rd_sel;
    logic                          irq_line;
    logic                          mirror_horizontal;
  } result_t;

  // Mapper state.
  logic [mmc3_pkg::BankRegW-1:0]  bank_regs_q [8];
  logic [mmc3_pkg::BankRegW-1:0]  bank_regs_d [8];
  logic [2:0]                     target_q, target_d;
  logic                           prg_mode_q, prg_mode_d;
  logic                           chr_inv_q, chr_inv_d;
  logic [mmc3_pkg::PrgBankW-1:0]  prg_tbl_q [4];
  logic [mmc3_pkg::PrgBankW-1:0]  prg_tbl_d [4];
  logic [mmc3_pkg::ChrBankW-1:0]  chr_tbl_q [8];
  logic [mmc3_pkg::ChrBankW-1:0]  chr_tbl_d [8];
  logic                           mirror_q, mirror_d;
  logic [7:0]                     reload_q, reload_d;
  logic [7:0]                     count_q, count_d;
  logic                           irq_en_q, irq_en_d;
  logic                           irq_pend_q, irq_pend_d;
  logic [mmc3_pkg::BankCntW-1:0]  bank_cnt_q;

  // Result pipeline.
  logic    s1_valid_q, s1_valid_d;
  result_t s1_res_q, s1_res_d;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  logic [mmc3_pkg::DataW-1:0] out_rdata_q;

  logic                       in_fire, s1_adv;
  logic                       ram_en, ram_we;
  logic [mmc3_pkg::DataW-1:0] ram_rdata;

  logic [mmc3_pkg::OpW-1:0]   op;
  logic [mmc3_pkg::AddrW-1:0] addr;
  logic [mmc3_pkg::DataW-1:0] wdata;
  logic                       in_ram, even;
  logic [mmc3_pkg::PrgBankW-1:0] last_bank, sec_last_bank;
  logic [mmc3_pkg::ChrBankW-1:0] two_k [4];
  logic [mmc3_pkg::ChrBankW-1:0] one_k [4];

  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || !out_valid_q || out_o.ready;
  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign op     = in_i.operation;
  assign addr   = in_i.address;
  assign wdata  = in_i.write_data;
  assign in_ram = (addr[15:13] == mmc3_pkg::RamWindow);
  assign even   = !addr[0];

  assign last_bank     = {bank_cnt_q[4:0], 1'b0} - mmc3_pkg::PrgBankW'(1);
  assign sec_last_bank = {bank_cnt_q[4:0], 1'b0} - mmc3_pkg::PrgBankW'(2);

  always_comb begin
    bank_regs_d = bank_regs_q;
    target_d    = target_q;
    prg_mode_d  = prg_mode_q;
    chr_inv_d   = chr_inv_q;
    prg_tbl_d   = prg_tbl_q;
    chr_tbl_d   = chr_tbl_q;
    mirror_d    = mirror_q;
    reload_d    = reload_q;
    count_d     = count_q;
    irq_en_d    = irq_en_q;
    irq_pend_d  = irq_pend_q;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    for (int i = 0; i < 4; i++) begin
      two_k[i] = '0;
      one_k[i] = '0;
    end

    s1_res_d = '0;

    case (op)
      mmc3_pkg::OpCpuRead: begin
        if (in_ram) begin
          s1_res_d.handled = 1'b1;
          s1_res_d.ram_hit = 1'b1;
          s1_res_d.rd_sel  = 1'b1;
          ram_en           = in_fire;
        end else if (addr[15]) begin
          s1_res_d.handled        = 1'b1;
          s1_res_d.mapped_address = {prg_tbl_q[addr[14:13]], addr[12:0]};
        end
      end
      mmc3_pkg::OpCpuWrite: begin
        if (in_ram) begin
          s1_res_d.handled = 1'b1;
          s1_res_d.ram_hit = 1'b1;
          ram_en           = in_fire;
          ram_we           = 1'b1;
        end else if (addr[15]) begin
          case (addr[14:13])
            mmc3_pkg::WinBank: begin
              if (even) begin
                target_d   = wdata[2:0];
                prg_mode_d = wdata[6];
                chr_inv_d  = wdata[7];
              end else begin
                bank_regs_d[target_q] = wdata;
                // Candidate CHR entries from the registers after this write.
                // The odd half of a 2KB bank is the even bank with bit 0 set.
                two_k[0] = {bank_regs_d[0][7:1], 1'b0};
                two_k[1] = {bank_regs_d[0][7:1], 1'b1};
                two_k[2] = {bank_regs_d[1][7:1], 1'b0};
                two_k[3] = {bank_regs_d[1][7:1], 1'b1};
                for (int i = 0; i < 4; i++) begin
                  one_k[i] = bank_regs_d[i+2];
                end
                // Tables follow the mode bits as they stand now.
                for (int i = 0; i < 4; i++) begin
                  chr_tbl_d[i]   = chr_inv_q ? one_k[i] : two_k[i];
                  chr_tbl_d[i+4] = chr_inv_q ? two_k[i] : one_k[i];
                end
                if (prg_mode_q) begin
                  prg_tbl_d[2] = bank_regs_d[6][5:0];
                  prg_tbl_d[0] = sec_last_bank;
                end else begin
                  prg_tbl_d[0] = bank_regs_d[6][5:0];
                  prg_tbl_d[2] = sec_last_bank;
                end
                prg_tbl_d[1] = bank_regs_d[7][5:0];
                prg_tbl_d[3] = last_bank;
              end
            end
            mmc3_pkg::WinMirror: begin
              if (even) begin
                mirror_d = wdata[0];
              end
            end
            mmc3_pkg::WinIrqCnt: begin
              if (even) begin
                reload_d = wdata;
              end else begin
                count_d = '0;
              end
            end
            mmc3_pkg::WinIrqEn: begin
              if (even) begin
                irq_en_d   = 1'b0;
                irq_pend_d = 1'b0;
              end else begin
                irq_en_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      mmc3_pkg::OpPpuRead: begin
        if (addr[15:13] == 3'b000) begin
          s1_res_d.handled        = 1'b1;
          s1_res_d.mapped_address =
            mmc3_pkg::MapAddrW'({chr_tbl_q[addr[12:10]], addr[9:0]});
        end
      end
      mmc3_pkg::OpScanline: begin
        count_d = (count_q == '0) ? reload_q : count_q - 8'd1;
        if (count_d == '0 && irq_en_q) begin
          irq_pend_d = 1'b1;
        end
      end
      mmc3_pkg::OpIrqClear: begin
        irq_pend_d = 1'b0;
      end
      default: begin
      end
    endcase

    s1_res_d.irq_line          = irq_pend_d;
    s1_res_d.mirror_horizontal = mirror_d;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        bank_regs_q[i] <= '0;
        chr_tbl_q[i]   <= '0;
      end
      prg_tbl_q[0] <= mmc3_pkg::PrgBankW'(0);
      prg_tbl_q[1] <= mmc3_pkg::PrgBankW'(1);
      prg_tbl_q[2] <= mmc3_pkg::PrgSecLastRst;
      prg_tbl_q[3] <= mmc3_pkg::PrgLastReset;
      target_q    <= '0;
      prg_mode_q  <= 1'b0;
      chr_inv_q   <= 1'b0;
      mirror_q    <= 1'b1;
      reload_q    <= '0;
      count_q     <= '0;
      irq_en_q    <= 1'b0;
      irq_pend_q  <= 1'b0;
      bank_cnt_q  <= mmc3_pkg::BankCntReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        bank_regs_q <= bank_regs_d;
        target_q    <= target_d;
        prg_mode_q  <= prg_mode_d;
        chr_inv_q   <= chr_inv_d;
        prg_tbl_q   <= prg_tbl_d;
        chr_tbl_q   <= chr_tbl_d;
        mirror_q    <= mirror_d;
        reload_q    <= reload_d;
        count_q     <= count_d;
        irq_en_q    <= irq_en_d;
        irq_pend_q  <= irq_pend_d;
      end
      if (cfg_i.valid) begin
        bank_cnt_q <= cfg_i.prg_bank_count;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_res_q <= s1_res_d;
    end
    if (s1_adv) begin
      out_res_q   <= s1_res_q;
      out_rdata_q <= s1_res_q.rd_sel ? ram_rdata : '0;
    end
  end

  mmc3_ram #(
    .Width (mmc3_pkg::DataW),
    .Depth (PRG_RAM_DEPTH)
  ) u_prg_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (addr[RamAw-1:0]),
    .wdata_i (wdata),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid             = out_valid_q;
  assign out_o.handled           = out_res_q.handled;
  assign out_o.ram_hit           = out_res_q.ram_hit;
  assign out_o.mapped_address    = out_res_q.mapped_address;
  assign out_o.read_data         = out_rdata_q;
  assign out_o.irq_line          = out_res_q.irq_line;
  assign out_o.mirror_horizontal = out_res_q.mirror_horizontal;

endmodule
